/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the weighted ticket draw table.
// No dependencies; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/wtd_pkg.sv */
// Package of the weighted ticket draw table: request and result structs,
// operation and state codes, default sizes. No dependencies.
`default_nettype none

package wtd_pkg;

  localparam int MAX_TICKETS_DEF = 256;
  localparam int ID_BITS_DEF     = 8;

  localparam int OP_W   = 2;
  localparam int MID_W  = 8;
  localparam int CPY_W  = 9;
  localparam int RND_W  = 32;
  localparam int OCC_W  = 9;
  localparam int RMV_W  = 9;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_DRAW   = 2'd3
  } wtd_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_DIV,
    ST_FETCH
  } wtd_state_t;

  typedef struct packed {
    wtd_op_t           op;
    logic [MID_W-1:0]  machine_id;
    logic [CPY_W-1:0]  copies;
    logic [RND_W-1:0]  random_value;
  } wtd_req_t;

  typedef struct packed {
    logic [MID_W-1:0]  drawn_id;
    logic              drawn_valid;
    logic [OCC_W-1:0]  occupancy;
    logic              overflow;
    logic [RMV_W-1:0]  removed_count;
  } wtd_res_t;

endpackage

`default_nettype wire

/* rtl/core/wtd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module wtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wtd_mod_unit.sv */
// Restoring remainder unit: a 32-bit dividend modulo a table-count divisor,
// one quotient bit per cycle. Uses wtd_pkg for the dividend width.
`default_nettype none

module wtd_mod_unit
  import wtd_pkg::*;
#(
  parameter int CW = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [RND_W-1:0] dividend,
  input  wire logic [CW-1:0]    divisor,
  output logic                  done,
  output logic      [CW-1:0]    remainder
);

  localparam int STEPS  = RND_W;
  localparam int STEP_W = $clog2(STEPS);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RND_W-1:0]  dvd_r, dvd_nxt;
  logic [CW-1:0]     dvs_r, dvs_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [CW:0]       trial;

  assign trial = {rem_r, dvd_r[RND_W-1]};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (run_r) begin
      dvd_nxt  = {dvd_r[RND_W-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = CW'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = CW'(trial);
      end
      if (step_r == STEP_W'(STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

/* rtl/core/weighted_ticket_draw_table_core.sv */
// Top level of the weighted ticket draw table: control sequencer around the
// ticket RAM (wtd_ram) and the remainder unit (wtd_mod_unit). Uses wtd_pkg.
`default_nettype none
`include "assert_macros.svh"

// The block keeps an ordered table of ticket identifiers in one RAM and takes
// one request at a time: a request is accepted on a rising edge with start
// high and busy low, and exactly one result follows, shown on out_res for a
// single cycle while out_valid is high. The receiver cannot stall, so the
// result must be captured in that cycle; busy drops in the same cycle the
// result appears, so the next request can be taken right away. A clear
// empties the table and answers straight from the idle state; an add makes
// one RAM write per ticket, stopping early when the table is full; a remove
// streams the whole table through the RAM read port, writes back each
// surviving entry once its read data arrives, and then closes out the scan;
// compaction happens in place through the write port; a draw on an empty
// table answers straight from the idle state, and otherwise runs the 32-step
// remainder unit followed by one RAM read. The RAM contents are not cleared
// at reset; only entries below the occupancy are ever read.
module weighted_ticket_draw_table_core
  import wtd_pkg::*;
#(
  parameter int MAX_TICKETS = MAX_TICKETS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire wtd_req_t in_req,
  output logic          out_valid,
  output wtd_res_t      out_res
);

  // AW addresses the table, CW can also hold the full occupancy.
  localparam int AW = $clog2(MAX_TICKETS);
  localparam int CW = $clog2(MAX_TICKETS + 1);

  wtd_state_t state_r, state_nxt;

  logic [CW-1:0]      cnt_r, cnt_nxt;        // tickets held
  logic [CPY_W-1:0]   copies_r, copies_nxt;  // copies still to add, or limit
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [CW-1:0]      k_r, k_nxt;            // scan read position
  logic [CW-1:0]      w_r, w_nxt;            // scan write position
  logic               pend_r, pend_nxt;      // read data due this cycle
  logic [RMV_W-1:0]   removed_r, removed_nxt;
  logic               out_valid_r, out_valid_nxt;
  wtd_res_t           out_res_r, out_res_nxt;

  logic               accept;
  logic               full;
  logic               add_done;
  logic               issue;
  logic               scan_done;
  logic               match;
  logic               fin;
  wtd_res_t           res_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ID_BITS-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ID_BITS-1:0] ram_rdata;

  logic               div_start;
  logic               div_done;
  logic [CW-1:0]      div_rem;

  wtd_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (MAX_TICKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wtd_mod_unit #(
    .CW (CW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_req.random_value),
    .divisor   (cnt_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (cnt_r == CW'(MAX_TICKETS));

  // An add ends when all copies are written or the table has filled up.
  assign add_done = (copies_r == '0) || full;

  // During a remove scan one entry is read per cycle; the entry read in the
  // previous cycle is either dropped as a match or written back at w_r.
  // Since w_r never passes the read position, compaction in place is safe.
  assign issue     = (k_r != cnt_r);
  assign scan_done = !issue && !pend_r;
  assign match     = pend_r && (removed_r < copies_r) && (ram_rdata == id_r);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.op)
            OP_CLEAR:  state_nxt = ST_IDLE;
            OP_ADD:    state_nxt = ST_ADD;
            OP_REMOVE: state_nxt = ST_SCAN;
            OP_DRAW:   state_nxt = (cnt_r == '0) ? ST_IDLE : ST_DIV;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (add_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    cnt_nxt     = cnt_r;
    copies_nxt  = copies_r;
    id_nxt      = id_r;
    k_nxt       = k_r;
    w_nxt       = w_r;
    pend_nxt    = pend_r;
    removed_nxt = removed_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    div_start   = 1'b0;
    fin         = 1'b0;
    res_d       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.op)
            OP_CLEAR: begin
              cnt_nxt = '0;
              fin     = 1'b1;
            end
            OP_ADD: begin
              copies_nxt = in_req.copies;
              id_nxt     = ID_BITS'(in_req.machine_id);
            end
            OP_REMOVE: begin
              copies_nxt  = in_req.copies;
              id_nxt      = ID_BITS'(in_req.machine_id);
              k_nxt       = '0;
              w_nxt       = '0;
              pend_nxt    = 1'b0;
              removed_nxt = '0;
            end
            OP_DRAW: begin
              if (cnt_r == '0) begin
                fin = 1'b1;
              end else begin
                div_start = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_ADD: begin
        if (add_done) begin
          fin            = 1'b1;
          res_d.overflow = (copies_r != '0);
          res_d.occupancy = OCC_W'(cnt_r);
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = cnt_r[AW-1:0];
          ram_wdata  = id_r;
          cnt_nxt    = cnt_r + 1'b1;
          copies_nxt = copies_r - 1'b1;
        end
      end
      ST_SCAN: begin
        ram_re    = issue;
        ram_raddr = k_r[AW-1:0];
        pend_nxt  = issue;
        if (issue) begin
          k_nxt = k_r + 1'b1;
        end
        if (pend_r) begin
          if (match) begin
            removed_nxt = removed_r + 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = w_r[AW-1:0];
            ram_wdata = ram_rdata;
            w_nxt     = w_r + 1'b1;
          end
        end
        if (scan_done) begin
          cnt_nxt             = w_r;
          fin                 = 1'b1;
          res_d.occupancy     = OCC_W'(w_r);
          res_d.removed_count = removed_r;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ram_re    = 1'b1;
          ram_raddr = div_rem[AW-1:0];
        end
      end
      ST_FETCH: begin
        fin               = 1'b1;
        res_d.drawn_id    = MID_W'(ram_rdata);
        res_d.drawn_valid = 1'b1;
        res_d.occupancy   = OCC_W'(cnt_r);
      end
      default: begin
        fin = 1'b0;
      end
    endcase
    // A clear reports an empty table; everything else reports cnt_nxt.
    if (fin && (state_r == ST_IDLE)) begin
      res_d.occupancy = OCC_W'(cnt_nxt);
    end
    out_valid_nxt = fin;
    out_res_nxt   = fin ? res_d : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    copies_r  <= copies_nxt;
    id_r      <= id_nxt;
    k_r       <= k_nxt;
    w_r       <= w_nxt;
    pend_r    <= pend_nxt;
    removed_r <= removed_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // The table never holds more tickets than it has entries.
  `ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_TICKETS))
  // A RAM fetch for a draw only happens on a nonempty table.
  `ASSERT_SAME(a_fetch_nonempty, clk, rst_n, state_r == ST_FETCH, cnt_r != '0)
  // The remainder unit only finishes while the sequencer waits for it.
  `ASSERT_SAME(a_div_owner, clk, rst_n, div_done, state_r == ST_DIV)
  // A remove never drops more tickets than were requested.
  `ASSERT_SAME(a_removed_limit, clk, rst_n, state_r == ST_SCAN, removed_r <= copies_r)
  // The write pointer of a scan never overtakes the read pointer.
  `ASSERT_NEXT(a_scan_order, clk, rst_n, state_r == ST_SCAN && state_nxt == ST_SCAN,
               w_r <= k_r)

endmodule

`default_nettype wire

/* bench/tb_weighted_ticket_draw_table_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for weighted_ticket_draw_table_core: a shadow ticket table
// predicts every result, directed and random requests exercise the table.
// Depends on wtd_pkg and the RTL of the weighted ticket draw table.

module tb_weighted_ticket_draw_table_core;
  import wtd_pkg::*;

  // Shadow copy of the ticket table. Each accepted request is applied to the
  // shadow table, and the result it must produce is queued. Results from the
  // block are matched in order against that queue.
  class ticket_table_tracker;
    bit [MID_W-1:0] shadow_ids [MAX_TICKETS_DEF];
    int unsigned    shadow_count;
    wtd_res_t       pending_results[$];
    int unsigned    errors;
    int unsigned    op_seen[4];
    int unsigned    overflows;
    int unsigned    valid_draws;
    int unsigned    checked;

    function void note_request(wtd_req_t req);
      wtd_res_t    res;
      int unsigned wr;
      res = '0;
      wr  = 0;
      case (req.op)
        OP_CLEAR: begin
          shadow_count = 0;
        end
        OP_ADD: begin
          // Tickets go in at the tail until the table is full.
          for (int unsigned k = 0; k < req.copies; k++) begin
            if (shadow_count >= MAX_TICKETS_DEF) begin
              res.overflow = 1'b1;
              break;
            end
            shadow_ids[shadow_count] = req.machine_id;
            shadow_count++;
          end
        end
        OP_REMOVE: begin
          // Drop the first matches and slide the survivors down in order.
          for (int unsigned k = 0; k < shadow_count; k++) begin
            if (res.removed_count < req.copies && shadow_ids[k] == req.machine_id) begin
              res.removed_count = res.removed_count + 1'b1;
            end else begin
              shadow_ids[wr] = shadow_ids[k];
              wr++;
            end
          end
          shadow_count = wr;
        end
        OP_DRAW: begin
          if (shadow_count != 0) begin
            res.drawn_id    = shadow_ids[req.random_value % shadow_count];
            res.drawn_valid = 1'b1;
          end
        end
        default: ;
      endcase
      res.occupancy = OCC_W'(shadow_count);
      op_seen[req.op]++;
      if (res.overflow) overflows++;
      if (res.drawn_valid) valid_draws++;
      pending_results.push_back(res);
    endfunction

    function void report_field(string name, int unsigned want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endfunction

    function void check_result(wtd_res_t got);
      wtd_res_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.drawn_id !== want.drawn_id)
        report_field("drawn_id", want.drawn_id, got.drawn_id);
      if (got.drawn_valid !== want.drawn_valid)
        report_field("drawn_valid", want.drawn_valid, got.drawn_valid);
      if (got.occupancy !== want.occupancy)
        report_field("occupancy", want.occupancy, got.occupancy);
      if (got.overflow !== want.overflow)
        report_field("overflow", want.overflow, got.overflow);
      if (got.removed_count !== want.removed_count)
        report_field("removed_count", want.removed_count, got.removed_count);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  wtd_req_t in_req;
  logic     out_valid;
  wtd_res_t out_res;

  ticket_table_tracker tracker;

  // When set, requests follow each other with no idle cycles in between.
  bit back_to_back;

  weighted_ticket_draw_table_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always #5 clk = ~clk;

  // The receiver cannot stall: every cycle with the strobe high carries one
  // result, and it is checked at the edge that ends that cycle. An unknown
  // strobe is treated as a result too, so it cannot slip through unnoticed.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      tracker.check_result(out_res);
    end
  end

  // Present one request after a random idle gap and hold it until the block
  // takes it, which happens at an edge where start is high and busy is low.
  // The request goes into the shadow table at that same edge.
  task automatic send_request(input wtd_op_t op, input logic [MID_W-1:0] id,
                              input logic [CPY_W-1:0] cnt, input logic [RND_W-1:0] rnd);
    wtd_req_t    req;
    int unsigned gap;
    req.op           = op;
    req.machine_id   = id;
    req.copies       = cnt;
    req.random_value = rnd;
    gap = back_to_back ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_request(req);
  endtask

  // Stimulus: a directed pass through the corners of the table, then a long
  // random stretch built around a small rotating set of identifiers, so that
  // removes find matches and draws land on tables of many shapes.
  initial begin
    logic [MID_W-1:0] id_set [4];
    int unsigned      roll;
    wtd_op_t          op;
    logic [MID_W-1:0] id;
    logic [CPY_W-1:0] cnt;
    logic [RND_W-1:0] rnd;

    tracker      = new();
    back_to_back = 1'b0;
    start  <= 1'b0;
    in_req <= '0;
    rst_n  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: a draw finds nothing, a remove finds nothing.
    send_request(OP_DRAW, 8'h00, 9'd0, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 8'h00, 9'd256, 32'h0000_0000);
    // Adding zero copies leaves the table alone.
    send_request(OP_ADD, 8'hFF, 9'd0, 32'h0);
    send_request(OP_ADD, 8'h00, 9'd1, 32'h0);
    send_request(OP_ADD, 8'hFF, 9'd3, 32'h0);
    // Fill past capacity, then try to add to a full table.
    send_request(OP_ADD, 8'h5A, 9'd256, 32'h0);
    send_request(OP_ADD, 8'h01, 9'd1, 32'h0);
    // Draws at both ends of a full table.
    send_request(OP_DRAW, 8'h00, 9'd0, 32'h0000_0000);
    send_request(OP_DRAW, 8'h00, 9'd0, 32'hFFFF_FFFF);
    // Partial remove, then a remove asking for more than remain.
    send_request(OP_REMOVE, 8'hFF, 9'd2, 32'h0);
    send_request(OP_REMOVE, 8'hFF, 9'd5, 32'h0);
    send_request(OP_REMOVE, 8'h5A, 9'd0, 32'h0);
    send_request(OP_DRAW, 8'hFF, 9'd511 >> 1, 32'h0000_0001);
    send_request(OP_REMOVE, 8'h5A, 9'd256, 32'h0);
    send_request(OP_DRAW, 8'h00, 9'd0, 32'h8000_0000);
    // Removing the only entry, and removing the entry at the tail.
    send_request(OP_REMOVE, 8'h00, 9'd1, 32'h0);
    send_request(OP_ADD, 8'hAA, 9'd2, 32'h0);
    send_request(OP_ADD, 8'h55, 9'd1, 32'h0);
    send_request(OP_REMOVE, 8'h55, 9'd1, 32'h0);
    send_request(OP_DRAW, 8'h00, 9'd0, 32'h8000_0001);
    // Clear a populated table, then fill it exactly to capacity.
    send_request(OP_CLEAR, 8'hFF, 9'd256, 32'hFFFF_FFFF);
    send_request(OP_DRAW, 8'h00, 9'd0, 32'h1234_5678);
    send_request(OP_ADD, 8'h33, 9'd256, 32'h0);
    send_request(OP_DRAW, 8'h00, 9'd0, 32'hDEAD_BEEF);
    send_request(OP_CLEAR, 8'h00, 9'd0, 32'h0);

    for (int n = 0; n < 1400; n++) begin
      // Every hundred requests pick a fresh identifier set and decide whether
      // this stretch runs with or without idle cycles.
      if (n % 100 == 0) begin
        foreach (id_set[i]) id_set[i] = MID_W'($urandom_range(0, 255));
        back_to_back = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 4)       op = OP_CLEAR;
      else if (roll < 40) op = OP_ADD;
      else if (roll < 65) op = OP_REMOVE;
      else                op = OP_DRAW;
      id = ($urandom_range(0, 4) == 0) ? MID_W'($urandom_range(0, 255))
                                       : id_set[$urandom_range(0, 3)];
      // Mostly small counts keep adds and removes short; a few go wide.
      roll = $urandom_range(0, 99);
      if (roll < 70)      cnt = CPY_W'($urandom_range(0, 6));
      else if (roll < 92) cnt = CPY_W'($urandom_range(0, 40));
      else                cnt = CPY_W'($urandom_range(0, 256));
      roll = $urandom_range(0, 3);
      if (roll < 2)       rnd = $urandom;
      else if (roll == 2) rnd = $urandom_range(0, 300);
      else                rnd = 32'hFFFF_FFFF - $urandom_range(0, 300);
      send_request(op, id, cnt, rnd);
    end

    start <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    // Longer than the slowest request, so a stray extra result is caught.
    repeat (300) @(posedge clk);

    $display("Checked %0d results: %0d clears, %0d adds, %0d removes, %0d draws.",
             tracker.checked, tracker.op_seen[OP_CLEAR], tracker.op_seen[OP_ADD],
             tracker.op_seen[OP_REMOVE], tracker.op_seen[OP_DRAW]);
    $display("Adds cut short by a full table: %0d; draws from a nonempty table: %0d.",
             tracker.overflows, tracker.valid_draws);
    if (tracker.errors == 0) begin
      $display("weighted_ticket_draw_table_core regression: pass");
    end else begin
      $display("weighted_ticket_draw_table_core regression: fail");
    end
    $finish;
  end

  // Safety net far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", tracker.pending_results.size());
    $display("weighted_ticket_draw_table_core regression: fail");
    $finish;
  end

endmodule
